@@ sv/bicubic_image_resampler_unit_macros.svh @@
// Assertion macros for the bicubic resampler checker.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef BICUBIC_IMAGE_RESAMPLER_UNIT_MACROS_SVH
`define BICUBIC_IMAGE_RESAMPLER_UNIT_MACROS_SVH

// clocked assertion with explicit clock and reset
`define BIR_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// assertion on the local clock and reset
`define BIR_ASSERT(label, prop, msg) `BIR_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ sv/bir_pkg.sv @@
// Shared types, constants and helpers of the bicubic resampler.
// No dependencies.
`default_nettype none

package bir_pkg;

   localparam int SAMPLE_BITS    = 18;
   localparam int COORD_BITS     = 8;
   localparam int CFG_BITS       = 9;
   localparam int CSR_INDEX_BITS = 8;

   // datapath widths
   localparam int OPND_BITS  = SAMPLE_BITS + 6;   // row values with headroom
   localparam int COEF_BITS  = OPND_BITS + 4;
   localparam int SUM_BITS   = COEF_BITS + 6;
   localparam int FRAC_BITS  = 17;                // fraction, signed positive
   localparam int PROD_BITS  = SUM_BITS + FRAC_BITS;
   localparam int VAL_BITS   = SUM_BITS + 2;
   localparam int POS_BITS   = 21;
   localparam int NUM_BITS   = 34;
   localparam int DIV_BITS   = 10;
   localparam int CNT_BITS   = 6;
   localparam int DIV_STEPS  = NUM_BITS;
   localparam int FETCH_WORDS = 16;
   localparam int PASS_COL   = 4;

   typedef enum logic [0:0] {
      OP_STORE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SOURCE_WIDTH  = 8'd0,
      REG_SOURCE_HEIGHT = 8'd1,
      REG_TARGET_WIDTH  = 8'd2,
      REG_TARGET_HEIGHT = 8'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_BASE,
      ST_FETCH,
      ST_CUBIC,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_COEF,
      PH_MUL1,
      PH_MUL2,
      PH_MUL3,
      PH_ROUND
   } phase_type;

   typedef struct packed {
      logic       store_write;
      logic       query_start;
      logic       div_step;
      logic       base_load;
      logic       fetch_issue;
      logic       fetch_capture;
      logic [3:0] fetch_index;
      logic       cubic_en;
      logic       col_pass;
      phase_type  phase;
      logic       load_out;
   } cmd_type;

   // clamp a signed index into 0..size-1
   function automatic logic [POS_BITS-1:0] clamp_index(
         input logic signed [POS_BITS-1:0] v,
         input logic [CFG_BITS-1:0] size);
      logic signed [POS_BITS-1:0] lim;
      lim = $signed(POS_BITS'(size) - POS_BITS'(1));
      if (v < 0) begin
         return '0;
      end else if (v > lim) begin
         return lim;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

@@ sv/bir_ifs.sv @@
// Channel interfaces of the bicubic resampler: request, response, register write.
// Depends on bir_pkg.
`default_nettype none

interface bir_req_if;
   logic                                 valid;
   logic                                 ready;
   bir_pkg::op_type                      op;
   logic [bir_pkg::COORD_BITS-1:0]       column;
   logic [bir_pkg::COORD_BITS-1:0]       row;
   logic signed [bir_pkg::SAMPLE_BITS-1:0] sample;
   modport source (output valid, output op, output column, output row, output sample,
                   input ready);
   modport sink   (input valid, input op, input column, input row, input sample,
                   output ready);
endinterface

interface bir_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bir_pkg::SAMPLE_BITS-1:0] pixel;
   logic [bir_pkg::COORD_BITS-1:0]       out_column;
   logic [bir_pkg::COORD_BITS-1:0]       out_row;
   modport source (output valid, output pixel, output out_column, output out_row,
                   input ready);
   modport sink   (input valid, input pixel, input out_column, input out_row,
                   output ready);
endinterface

interface bir_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bir_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [bir_pkg::CFG_BITS-1:0]        data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bir_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module bir_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/bir_datapath.sv @@
// Datapath of the bicubic resampler: registers, position dividers, image memory,
// neighborhood registers and the shared cubic unit. Depends on bir_pkg, bir_ram.
`default_nettype none

module bir_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire bir_pkg::cmd_type                       cmd,
   input  wire logic [bir_pkg::COORD_BITS-1:0]         req_column,
   input  wire logic [bir_pkg::COORD_BITS-1:0]         req_row,
   input  wire logic signed [bir_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                   csr_write,
   input  wire logic [bir_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [bir_pkg::CFG_BITS-1:0]           csr_data,
   output logic signed [bir_pkg::SAMPLE_BITS-1:0]      rsp_pixel,
   output logic [bir_pkg::COORD_BITS-1:0]              rsp_out_column,
   output logic [bir_pkg::COORD_BITS-1:0]              rsp_out_row
);

   localparam int SB   = bir_pkg::SAMPLE_BITS;
   localparam int CB   = bir_pkg::CFG_BITS;
   localparam int OW   = bir_pkg::OPND_BITS;
   localparam int CW   = bir_pkg::COEF_BITS;
   localparam int SW   = bir_pkg::SUM_BITS;
   localparam int TW   = bir_pkg::FRAC_BITS;
   localparam int MW   = bir_pkg::PROD_BITS;
   localparam int VW   = bir_pkg::VAL_BITS;
   localparam int PB   = bir_pkg::POS_BITS;
   localparam int NB   = bir_pkg::NUM_BITS;
   localparam int DB   = bir_pkg::DIV_BITS;
   localparam int IXW  = $clog2(MAX_WIDTH);
   localparam int IYW  = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW   = $clog2(DEPTH);
   localparam logic signed [OW-1:0] SAT_HI = OW'((2 ** (SB - 1)) - 1);
   localparam logic signed [OW-1:0] SAT_LO = OW'(-(2 ** (SB - 1)));

   function automatic logic [CB-1:0] clamp_size(input logic [CB-1:0] v, input int maxv);
      if (v == '0) begin
         return CB'(1);
      end else if (int'(v) > maxv) begin
         return CB'(maxv);
      end
      return v;
   endfunction

   // configuration
   logic [CB-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [CB-1:0] sw, sh, dw, dh;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= CB'(256);
         src_h_ff <= CB'(256);
         dst_w_ff <= CB'(256);
         dst_h_ff <= CB'(256);
      end else if (csr_write) begin
         case (csr_index)
            bir_pkg::REG_SOURCE_WIDTH:  src_w_ff <= csr_data;
            bir_pkg::REG_SOURCE_HEIGHT: src_h_ff <= csr_data;
            bir_pkg::REG_TARGET_WIDTH:  dst_w_ff <= csr_data;
            bir_pkg::REG_TARGET_HEIGHT: dst_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign sw = clamp_size(src_w_ff, MAX_WIDTH);
   assign sh = clamp_size(src_h_ff, MAX_HEIGHT);
   assign dw = clamp_size(dst_w_ff, MAX_WIDTH);
   assign dh = clamp_size(dst_h_ff, MAX_HEIGHT);

   // query coordinates
   logic [bir_pkg::COORD_BITS-1:0] col_ff, row_ff;

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         col_ff <= req_column;
         row_ff <= req_row;
      end
   end

   // position dividers, lane 0 is x and lane 1 is y
   logic [NB-1:0]   num_ff [2];
   logic [NB-1:0]   quo_ff [2];
   logic [DB-1:0]   rem_ff [2];
   logic [DB-1:0]   den_ff [2];
   logic [NB-1:0]   num_start [2];
   logic [DB-1:0]   den_start [2];
   logic [DB:0]     rem_sh [2];
   logic            rem_ge [2];
   logic [DB-1:0]   rem_in [2];

   assign num_start[0] = {18'(({col_ff[7:0], 1'b1})) * 18'(sw), 16'b0};
   assign num_start[1] = {18'(({row_ff[7:0], 1'b1})) * 18'(sh), 16'b0};
   assign den_start[0] = {dw, 1'b0};
   assign den_start[1] = {dh, 1'b0};

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem_sh[l] = {rem_ff[l], num_ff[l][NB-1]};
         rem_ge[l] = rem_sh[l] >= {1'b0, den_ff[l]};
         rem_in[l] = rem_ge[l] ? DB'(rem_sh[l] - {1'b0, den_ff[l]}) : rem_sh[l][DB-1:0];
      end
   end

   logic query_load_ff;

   // numerators load in the cycle after capture of the coordinates
   always_ff @(posedge clock) begin
      if (reset) begin
         query_load_ff <= 1'b0;
      end else begin
         query_load_ff <= cmd.query_start;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (query_load_ff) begin
            num_ff[l] <= num_start[l];
            den_ff[l] <= den_start[l];
            rem_ff[l] <= '0;
            quo_ff[l] <= '0;
         end else if (cmd.div_step) begin
            num_ff[l] <= {num_ff[l][NB-2:0], 1'b0};
            rem_ff[l] <= rem_in[l];
            quo_ff[l] <= {quo_ff[l][NB-2:0], rem_ge[l]};
         end
      end
   end

   // base indices and fractions
   logic [NB:0]             pos_x, pos_y;
   logic signed [PB-1:0]    base_x_ff, base_y_ff;
   logic [15:0]             tx_ff, ty_ff;

   assign pos_x = {1'b0, quo_ff[0]} + (NB + 1)'(32768);
   assign pos_y = {1'b0, quo_ff[1]} + (NB + 1)'(32768);

   always_ff @(posedge clock) begin
      if (cmd.base_load) begin
         base_x_ff <= $signed({2'b00, pos_x[NB:16]} - PB'(2));
         base_y_ff <= $signed({2'b00, pos_y[NB:16]} - PB'(2));
         tx_ff     <= pos_x[15:0];
         ty_ff     <= pos_y[15:0];
      end
   end

   // image memory
   logic signed [PB-1:0] fx, fy;
   logic [IXW-1:0]       xc;
   logic [IYW-1:0]       yc;
   logic [AW-1:0]        fetch_addr, store_addr, ram_addr;
   logic                 store_ok;
   logic [SB-1:0]        ram_rdata;

   assign fx = $signed(base_x_ff + PB'(cmd.fetch_index[1:0]));
   assign fy = $signed(base_y_ff + PB'(cmd.fetch_index[3:2]));
   assign xc = IXW'(bir_pkg::clamp_index(fx, sw));
   assign yc = IYW'(bir_pkg::clamp_index(fy, sh));
   assign fetch_addr = AW'(AW'(yc) * AW'(MAX_WIDTH) + AW'(xc));
   assign store_addr = AW'(AW'(req_row) * AW'(MAX_WIDTH) + AW'(req_column));
   assign store_ok   = (32'(req_column) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
   assign ram_addr   = cmd.store_write ? store_addr : fetch_addr;

   bir_ram #(
      .WIDTH (SB),
      .DEPTH (DEPTH)
   ) u_image (
      .clock (clock),
      .we    (cmd.store_write && store_ok),
      .addr  (ram_addr),
      .wdata (req_sample),
      .rdata (ram_rdata)
   );

   // neighborhood and row values, shifted through fixed places
   logic signed [SB-1:0] samples_ff [bir_pkg::FETCH_WORDS];
   logic signed [OW-1:0] rows_ff [4];

   // cubic unit
   logic signed [OW-1:0] op_a, op_b, op_c, op_d;
   logic signed [CW-1:0] ca, cb, cc;
   logic signed [CW-1:0] ca_ff, cb_ff, cc_ff;
   logic signed [OW-1:0] b_ff;
   logic signed [TW-1:0] t_ff;
   logic signed [SW-1:0] mul_a;
   logic signed [MW-1:0] m_ff, m_in;
   logic signed [VW-1:0] v;
   logic signed [OW-1:0] row_val, col_val;
   logic signed [SB-1:0] sat_val, pix_res_ff;

   always_comb begin
      if (cmd.col_pass) begin
         op_a = rows_ff[0];
         op_b = rows_ff[1];
         op_c = rows_ff[2];
         op_d = rows_ff[3];
      end else begin
         op_a = OW'(samples_ff[0]);
         op_b = OW'(samples_ff[1]);
         op_c = OW'(samples_ff[2]);
         op_d = OW'(samples_ff[3]);
      end
      ca = CW'(CW'(op_d) - CW'(op_a) + CW'(op_b) * 3 - CW'(op_c) * 3);
      cb = CW'(CW'(op_a) * 2 - CW'(op_b) * 5 + CW'(op_c) * 4 - CW'(op_d));
      cc = CW'(CW'(op_c) - CW'(op_a));
   end

   always_comb begin
      case (cmd.phase)
         bir_pkg::PH_MUL1: mul_a = SW'(ca_ff) <<< 4;
         bir_pkg::PH_MUL2: mul_a = SW'(m_ff >>> 16) + (SW'(cb_ff) <<< 4);
         bir_pkg::PH_MUL3: mul_a = SW'(m_ff >>> 16) + (SW'(cc_ff) <<< 4);
         default:          mul_a = '0;
      endcase
   end

   assign m_in    = MW'(mul_a) * MW'(t_ff);
   assign v       = (VW'(b_ff) <<< 5) + VW'(m_ff >>> 16);
   assign row_val = OW'((v + VW'(1)) >>> 1);
   assign col_val = OW'((v + VW'(256)) >>> 9);

   always_comb begin
      if (col_val > SAT_HI) begin
         sat_val = SB'(SAT_HI);
      end else if (col_val < SAT_LO) begin
         sat_val = SB'(SAT_LO);
      end else begin
         sat_val = SB'(col_val);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_capture) begin
         for (int i = 0; i < bir_pkg::FETCH_WORDS - 1; i++) begin
            samples_ff[i] <= samples_ff[i + 1];
         end
         samples_ff[bir_pkg::FETCH_WORDS - 1] <= $signed(ram_rdata);
      end
      if (cmd.cubic_en) begin
         case (cmd.phase)
            bir_pkg::PH_COEF: begin
               ca_ff <= ca;
               cb_ff <= cb;
               cc_ff <= cc;
               b_ff  <= op_b;
               t_ff  <= cmd.col_pass ? $signed({1'b0, ty_ff}) : $signed({1'b0, tx_ff});
            end
            bir_pkg::PH_MUL1, bir_pkg::PH_MUL2, bir_pkg::PH_MUL3: begin
               m_ff <= m_in;
            end
            bir_pkg::PH_ROUND: begin
               if (cmd.col_pass) begin
                  pix_res_ff <= sat_val;
               end else begin
                  // advance to the next source row
                  for (int i = 0; i < 3; i++) begin
                     rows_ff[i] <= rows_ff[i + 1];
                  end
                  rows_ff[3] <= row_val;
                  for (int i = 0; i < bir_pkg::FETCH_WORDS - 4; i++) begin
                     samples_ff[i] <= samples_ff[i + 4];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // output word
   logic signed [SB-1:0]           pixel_ff;
   logic [bir_pkg::COORD_BITS-1:0] out_col_ff, out_row_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         pixel_ff   <= pix_res_ff;
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
      end
   end

   assign rsp_pixel      = pixel_ff;
   assign rsp_out_column = out_col_ff;
   assign rsp_out_row    = out_row_ff;

endmodule

`default_nettype wire

@@ sv/bir_controller.sv @@
// Sequencer of the bicubic resampler: divide, fetch, cubic passes, output handoff.
// Depends on bir_pkg.
`default_nettype none

module bir_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire bir_pkg::op_type  req_op,
   input  wire logic             rsp_ready,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output bir_pkg::cmd_type      cmd
);

   localparam int CW = bir_pkg::CNT_BITS;

   bir_pkg::state_type state_ff, state_in;
   bir_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [2:0]         pass_ff, pass_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept, out_free;

   assign accept   = req_valid && (state_ff == bir_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pass_in  = pass_ff;
      phase_in = phase_ff;
      case (state_ff)
         bir_pkg::ST_IDLE: begin
            if (accept && req_op == bir_pkg::OP_QUERY) begin
               state_in = bir_pkg::ST_DIVIDE;
               cnt_in   = '0;
            end
         end
         bir_pkg::ST_DIVIDE: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(bir_pkg::DIV_STEPS)) begin
               state_in = bir_pkg::ST_BASE;
            end
         end
         bir_pkg::ST_BASE: begin
            state_in = bir_pkg::ST_FETCH;
            cnt_in   = '0;
         end
         bir_pkg::ST_FETCH: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(bir_pkg::FETCH_WORDS)) begin
               state_in = bir_pkg::ST_CUBIC;
               pass_in  = '0;
               phase_in = bir_pkg::PH_COEF;
            end
         end
         bir_pkg::ST_CUBIC: begin
            case (phase_ff)
               bir_pkg::PH_COEF: phase_in = bir_pkg::PH_MUL1;
               bir_pkg::PH_MUL1: phase_in = bir_pkg::PH_MUL2;
               bir_pkg::PH_MUL2: phase_in = bir_pkg::PH_MUL3;
               bir_pkg::PH_MUL3: phase_in = bir_pkg::PH_ROUND;
               default: begin
                  phase_in = bir_pkg::PH_COEF;
                  pass_in  = pass_ff + 3'd1;
                  if (pass_ff == 3'(bir_pkg::PASS_COL)) begin
                     state_in = bir_pkg::ST_DONE;
                  end
               end
            endcase
         end
         bir_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bir_pkg::ST_IDLE;
            end
         end
         default: state_in = bir_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd               = '0;
      cmd.phase         = phase_ff;
      cmd.col_pass      = (pass_ff == 3'(bir_pkg::PASS_COL));
      cmd.fetch_index   = cnt_ff[3:0];
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         bir_pkg::ST_IDLE: begin
            cmd.store_write = accept && req_op == bir_pkg::OP_STORE;
            cmd.query_start = accept && req_op == bir_pkg::OP_QUERY;
         end
         // first cycle loads the numerators, then one quotient bit a cycle
         bir_pkg::ST_DIVIDE: cmd.div_step = (cnt_ff != '0);
         bir_pkg::ST_BASE:   cmd.base_load = 1'b1;
         bir_pkg::ST_FETCH: begin
            cmd.fetch_issue   = cnt_ff < CW'(bir_pkg::FETCH_WORDS);
            cmd.fetch_capture = cnt_ff != '0;
         end
         bir_pkg::ST_CUBIC: cmd.cubic_en = 1'b1;
         bir_pkg::ST_DONE: begin
            cmd.load_out = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bir_pkg::ST_IDLE;
         phase_ff     <= bir_pkg::PH_COEF;
         cnt_ff       <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == bir_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ sv/bicubic_image_resampler_unit.sv @@
// Catmull-Rom bicubic image scaler over a stored source image.
// A store word is written on acceptance. A query runs the two position dividers
// (one quotient bit a cycle), the base index, sixteen reads of the single-port
// image memory, five passes of the shared cubic multiplier and the output handoff,
// which waits for the response channel. No new word is taken during a query; the
// next word can be accepted in the same cycle as the result turns valid.
// Synchronous reset clears control, sizes go to 256; datapath, image stay undefined.
`default_nettype none

module bicubic_image_resampler_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bir_req_if.sink    req_ch,
   bir_rsp_if.source  rsp_ch,
   bir_csr_if.sink    csr_ch
);

   bir_pkg::cmd_type cmd;
   logic             req_ready;
   logic             rsp_valid;

   bir_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .rsp_ready (rsp_ch.ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bir_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_column     (req_ch.column),
      .req_row        (req_ch.row),
      .req_sample     (req_ch.sample),
      .csr_write      (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .rsp_pixel      (rsp_ch.pixel),
      .rsp_out_column (rsp_ch.out_column),
      .rsp_out_row    (rsp_ch.out_row)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

endmodule

`default_nettype wire

@@ sv/bir_checker.sv @@
// Port-level checks of the bicubic resampler, bound to the top level.
// Depends on bir_pkg and bicubic_image_resampler_unit_macros.svh.
`default_nettype none
`include "bicubic_image_resampler_unit_macros.svh"

module bir_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire bir_pkg::op_type                        req_op,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [bir_pkg::SAMPLE_BITS-1:0] rsp_pixel,
   input wire logic [bir_pkg::COORD_BITS-1:0]         rsp_out_column,
   input wire logic [bir_pkg::COORD_BITS-1:0]         rsp_out_row
);

   `BIR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response word dropped")
   `BIR_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_pixel) && $stable(rsp_out_column) && $stable(rsp_out_row), "stalled response changed")
   `BIR_ASSERT(a_query_busy, req_valid && req_ready && req_op == bir_pkg::OP_QUERY |=> !req_ready, "query did not block input")
   `BIR_ASSERT(a_rsp_after_work, $rose(rsp_valid) |-> $past(!req_ready), "response without query work")

endmodule

bind bicubic_image_resampler_unit bir_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_op         (req_ch.op),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pixel      (rsp_ch.pixel),
   .rsp_out_column (rsp_ch.out_column),
   .rsp_out_row    (rsp_ch.out_row)
);

`default_nettype wire
